[hw/rtl/lpfi_pkg.sv]
// ----------------------------------------------------------------------------
// Linear-probe find-or-insert: shared package
// Widths, result codes and state encodings used by the front end, the
// hand-off queue, the probe engine and the top level.
// ----------------------------------------------------------------------------
package lpfi_pkg;

    localparam int KEY_W           = 64;
    localparam int HALF_W          = 32;
    localparam int SLOT_OUT_W      = 10;
    localparam int STATUS_W        = 2;
    localparam int DEF_TABLE_SLOTS = 1024;

    // The home-slot remainder is formed by reciprocal multiplication in steps:
    // estimate, product, difference and one correction.
    localparam int STEPS      = 4;
    localparam int STEP_W     = $clog2(STEPS);

    // Hand-off queue between the front end and the probe engine.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND    = 2'd0,
        ST_INSERTED = 2'd1,
        ST_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_REDUCE,
        F_HOLD
    } front_state_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_EMIT
    } back_state_t;

endpackage

[hw/rtl/linear_probe_find_or_insert.sv]
// ----------------------------------------------------------------------------
// Linear-probe find-or-insert
// Find-or-insert lookup of nonzero 64-bit keys in an open-addressing hash
// table with linear probing, split into a hashing front end and a probe
// engine joined by a short queue.
// ----------------------------------------------------------------------------
// Usage. Both sides behave as a queue. A key is taken at a rising edge with
// push high and full low. A result (slot and status) is shown while empty is
// low and is removed at a rising edge with pop high and empty low. Status is
// found, inserted or full; a full table, and a zero key, give slot zero.
//
// Flow. The front end reduces the 32-bit fold of the key modulo the table
// size, by multiplying with a fixed reciprocal and correcting once, and
// then hands the item to the queue. It takes no new key while it reduces,
// but can take the next key in the same cycle as it hands one to the queue.
// The probe engine reads the key table one slot at a time, since the table
// has a single read port, until it finds the key or a vacant slot or has
// wrapped back to the home slot.
//
// Reset. After reset the engine clears the key table, one slot per cycle;
// full stays high until that pass is over.
// Stalls. When pop is held low the finished result waits in the output
// register; keys are still taken until the two-entry queue and the front end
// are occupied, and then full is raised.
// ----------------------------------------------------------------------------
module linear_probe_find_or_insert import lpfi_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [KEY_W-1:0]      key,
    input  logic                  push,
    output logic                  full,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic [STATUS_W-1:0]   status,
    output logic                  empty,
    input  logic                  pop
);

    localparam int SLOT_W  = $clog2(TABLE_SLOTS);
    localparam int ENTRY_W = KEY_W + SLOT_W + 1;

    logic               clearing;
    logic               f_push;
    logic               q_full, q_empty, q_pop;
    logic [KEY_W-1:0]   f_key, b_key;
    logic [SLOT_W-1:0]  f_home, b_home;
    logic               f_zero, b_zero;
    logic [ENTRY_W-1:0] q_in, q_out;

    lpfi_front #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (!clearing),
        .key    (key),
        .push   (push),
        .full   (full),
        .q_push (f_push),
        .q_full (q_full),
        .q_key  (f_key),
        .q_home (f_home),
        .q_zero (f_zero)
    );

    assign q_in = {f_zero, f_home, f_key};

    lpfi_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    assign b_key  = q_out[KEY_W-1:0];
    assign b_home = q_out[KEY_W+SLOT_W-1:KEY_W];
    assign b_zero = q_out[ENTRY_W-1];

    lpfi_back #(
        .TABLE_SLOTS (TABLE_SLOTS),
        .SLOT_W      (SLOT_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .clearing (clearing),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .q_key    (b_key),
        .q_home   (b_home),
        .q_zero   (b_zero),
        .slot     (slot),
        .status   (status),
        .empty    (empty),
        .pop      (pop)
    );

    // No key may be taken while the table is still being cleared.
    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> full
    ) else $error("key accepted during table clearing");

    // A full-table result always reports slot zero.
    a_full_slot_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_FULL) |-> (slot == '0)
    ) else $error("full result with nonzero slot");

    // The probe engine only draws from the queue when it holds an item.
    a_pop_not_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty
    ) else $error("probe engine popped an empty queue");

    // No result appears while the table is still being cleared.
    a_no_result_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clearing |-> empty
    ) else $error("result shown during table clearing");

endmodule

[hw/rtl/lpfi_front.sv]
// ----------------------------------------------------------------------------
// Linear-probe find-or-insert: front end
// Accepts keys, folds them to 32 bits and reduces the fold modulo the table
// size by a fixed reciprocal multiplication, then hands the item to the
// queue.
// ----------------------------------------------------------------------------
module lpfi_front import lpfi_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [KEY_W-1:0]  key,
    input  logic              push,
    output logic              full,
    output logic              q_push,
    input  logic              q_full,
    output logic [KEY_W-1:0]  q_key,
    output logic [SLOT_W-1:0] q_home,
    output logic              q_zero
);

    // The quotient estimate from this reciprocal is at most one too small,
    // so a single compare and subtract finishes the remainder.
    localparam logic [HALF_W-1:0] MOD_W = HALF_W'(TABLE_SLOTS);
    localparam logic [HALF_W-1:0] RECIP = HALF_W'((64'd1 << HALF_W) / TABLE_SLOTS);

    front_state_t          state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [KEY_W-1:0]      key_reg;
    logic [HALF_W-1:0]     fold_reg;
    logic [HALF_W-1:0]     work_reg;
    logic [SLOT_W-1:0]     rem_reg;
    logic                  zero_reg;
    logic                  accept;
    logic [2*HALF_W-1:0]   prod;
    logic [HALF_W-1:0]     rem_fix;

    assign prod    = {{HALF_W{1'b0}}, fold_reg} * {{HALF_W{1'b0}}, RECIP};
    assign rem_fix = (work_reg >= MOD_W) ? work_reg - MOD_W : work_reg;

    always_comb
    begin
        full   = 1'b1;
        q_push = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                full = !en;
            end
            F_REDUCE:
            begin
                full = 1'b1;
            end
            F_HOLD:
            begin
                q_push = 1'b1;
                full   = q_full || !en;
            end
            default:
            begin
                full = 1'b1;
            end
        endcase
    end

    assign accept = push && !full;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_REDUCE;
                    step_next  = '0;
                end
            end
            F_REDUCE:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(STEPS - 1))
                begin
                    state_next = F_HOLD;
                end
            end
            F_HOLD:
            begin
                if (accept)
                begin
                    state_next = F_REDUCE;
                    step_next  = '0;
                end
                else if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            key_reg  <= key;
            fold_reg <= key[KEY_W-1:HALF_W] ^ key[HALF_W-1:0];
            rem_reg  <= '0;
            zero_reg <= (key == '0);
        end
        else if (state_reg == F_REDUCE)
        begin
            case (step_reg)
                STEP_W'(0):
                begin
                    work_reg <= prod[2*HALF_W-1:HALF_W];
                end
                STEP_W'(1):
                begin
                    work_reg <= work_reg * MOD_W;
                end
                STEP_W'(2):
                begin
                    work_reg <= fold_reg - work_reg;
                end
                default:
                begin
                    rem_reg <= rem_fix[SLOT_W-1:0];
                end
            endcase
        end
    end

    assign q_key  = key_reg;
    assign q_home = rem_reg;
    assign q_zero = zero_reg;

endmodule

[hw/rtl/lpfi_queue.sv]
// ----------------------------------------------------------------------------
// Linear-probe find-or-insert: hand-off queue
// A two-entry first-in first-out buffer between the front end and the
// probe engine, so that either side can stall without holding the other.
// ----------------------------------------------------------------------------
module lpfi_queue import lpfi_pkg::*; #(
    parameter int WIDTH = KEY_W
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hw/rtl/lpfi_back.sv]
// ----------------------------------------------------------------------------
// Linear-probe find-or-insert: probe engine
// Holds the key table, clears it after reset, walks the probe sequence one
// slot per cycle and places each result in the output register.
// ----------------------------------------------------------------------------
module lpfi_back import lpfi_pkg::*; #(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int SLOT_W      = $clog2(TABLE_SLOTS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    output logic                  clearing,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [KEY_W-1:0]      q_key,
    input  logic [SLOT_W-1:0]     q_home,
    input  logic                  q_zero,
    output logic [SLOT_OUT_W-1:0] slot,
    output logic [STATUS_W-1:0]   status,
    output logic                  empty,
    input  logic                  pop
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    back_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]     clr_addr_reg;
    logic [SLOT_W-1:0]     pos_reg, home_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    status_t               res_status_reg;
    logic                  out_valid_reg;
    logic [SLOT_OUT_W-1:0] out_slot_reg;
    status_t               out_status_reg;

    logic [KEY_W-1:0]      table_mem [TABLE_SLOTS];
    logic [KEY_W-1:0]      rd_data_reg;

    logic                  wr_en;
    logic [SLOT_W-1:0]     wr_addr;
    logic [KEY_W-1:0]      wr_data;
    logic [SLOT_W-1:0]     rd_addr;
    logic [SLOT_W-1:0]     pos_next;
    logic                  hit, vacant, wrapped;
    logic                  out_load, out_take;

    assign out_take = pop && out_valid_reg;
    assign pos_next = (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
    assign hit      = (rd_data_reg == key_reg);
    assign vacant   = (rd_data_reg == '0);
    assign wrapped  = (pos_next == home_reg);

    // Output decode
    always_comb
    begin
        clearing = 1'b0;
        q_pop    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = pos_reg;
        wr_data  = key_reg;
        rd_addr  = pos_next;
        out_load = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                clearing = 1'b1;
                wr_en    = 1'b1;
                wr_addr  = clr_addr_reg;
                wr_data  = '0;
            end
            B_IDLE:
            begin
                q_pop   = !q_empty;
                rd_addr = q_home;
            end
            B_PROBE:
            begin
                wr_en = !hit && vacant;
            end
            B_EMIT:
            begin
                out_load = !out_valid_reg || out_take;
            end
            default:
            begin
                clearing = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_addr_reg == LAST_SLOT)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = q_zero ? B_EMIT : B_PROBE;
                end
            end
            B_PROBE:
            begin
                if (hit || vacant || wrapped)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_take)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            key_reg        <= q_key;
            home_reg       <= q_home;
            pos_reg        <= q_home;
            res_slot_reg   <= '0;
            res_status_reg <= ST_FULL;
        end
        else if (state_reg == B_PROBE)
        begin
            if (hit)
            begin
                res_slot_reg   <= pos_reg;
                res_status_reg <= ST_FOUND;
            end
            else if (vacant)
            begin
                res_slot_reg   <= pos_reg;
                res_status_reg <= ST_INSERTED;
            end
            else if (wrapped)
            begin
                res_slot_reg   <= '0;
                res_status_reg <= ST_FULL;
            end
            else
            begin
                pos_reg <= pos_next;
            end
        end
        if (out_load)
        begin
            out_slot_reg   <= SLOT_OUT_W'(res_slot_reg);
            out_status_reg <= res_status_reg;
        end
    end

    // Key table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    assign slot   = out_slot_reg;
    assign status = out_status_reg;
    assign empty  = !out_valid_reg;

endmodule
